[src/ucm_pkg.sv]
// Shared types, constants and case-mapping tables for the Unicode case mapper.
package ucm_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] t_cp;

    typedef struct packed {
        t_cp ub;
        t_cp ue;
        t_cp lb;
        t_cp le;
    } t_range_row;

    typedef struct packed {
        t_cp up;
        t_cp lo;
    } t_pair_row;

    typedef struct packed {
        t_cp up;
        t_cp title;
        t_cp lo;
    } t_triple_row;

    // Mapping under the current mode flags, and the mapping with both flags clear.
    typedef struct packed {
        t_cp moded;
        t_cp plain;
    } t_map_res;

    localparam t_cp CAP_SIGMA   = 21'h003A3;
    localparam t_cp FINAL_SIGMA = 21'h003C2;

    localparam int N_OFFSET  = 11;
    localparam int N_ALT     = 17;
    localparam int N_DIRECT  = 21;
    localparam int N_DIGRAPH = 4;

    localparam t_range_row OFFSET_ROWS [N_OFFSET] = '{
        '{21'h00041, 21'h0005A, 21'h00061, 21'h0007A},
        '{21'h000C0, 21'h000D6, 21'h000E0, 21'h000F6},
        '{21'h000D8, 21'h000DE, 21'h000F8, 21'h000FE},
        '{21'h00388, 21'h0038A, 21'h003AD, 21'h003AF},
        '{21'h0038C, 21'h0038F, 21'h003CC, 21'h003CE},
        '{21'h00391, 21'h003A1, 21'h003B1, 21'h003C1},
        '{21'h003A3, 21'h003AB, 21'h003C3, 21'h003CB},
        '{21'h003D8, 21'h003DC, 21'h003D9, 21'h003DD},
        '{21'h003DE, 21'h003EE, 21'h003DF, 21'h003EF},
        '{21'h00410, 21'h0042F, 21'h00430, 21'h0044F},
        '{21'h00400, 21'h0040F, 21'h00450, 21'h0045F}
    };

    localparam t_range_row ALT_ROWS [N_ALT] = '{
        '{21'h00100, 21'h0012E, 21'h00101, 21'h0012F},
        '{21'h00132, 21'h00136, 21'h00133, 21'h00137},
        '{21'h00139, 21'h00147, 21'h0013A, 21'h00148},
        '{21'h0014A, 21'h00176, 21'h0014B, 21'h00177},
        '{21'h00179, 21'h0017D, 21'h0017A, 21'h0017E},
        '{21'h001A0, 21'h001A4, 21'h001A1, 21'h001A5},
        '{21'h001CD, 21'h001DB, 21'h001CE, 21'h001DC},
        '{21'h001DE, 21'h001EE, 21'h001DF, 21'h001EF},
        '{21'h001F8, 21'h0021E, 21'h001F9, 21'h0021F},
        '{21'h00222, 21'h00232, 21'h00223, 21'h00233},
        '{21'h00246, 21'h0024E, 21'h00247, 21'h0024F},
        '{21'h01E02, 21'h01E84, 21'h01E03, 21'h01E85},
        '{21'h00370, 21'h00376, 21'h00371, 21'h00377},
        '{21'h00460, 21'h00480, 21'h00461, 21'h00481},
        '{21'h0048A, 21'h004BE, 21'h0048B, 21'h004BF},
        '{21'h004C1, 21'h004CD, 21'h004C2, 21'h004CE},
        '{21'h004D0, 21'h004FE, 21'h004D1, 21'h004FF}
    };

    localparam t_pair_row DIRECT_ROWS [N_DIRECT] = '{
        '{21'h00178, 21'h000FF}, '{21'h00182, 21'h00183}, '{21'h00184, 21'h00185},
        '{21'h00187, 21'h00188}, '{21'h0018B, 21'h0018C}, '{21'h00191, 21'h00192},
        '{21'h00198, 21'h00199}, '{21'h001A7, 21'h001A8}, '{21'h001AC, 21'h001AD},
        '{21'h001AF, 21'h001B0}, '{21'h001B3, 21'h001B4}, '{21'h001B5, 21'h001B6},
        '{21'h001B8, 21'h001B9}, '{21'h001BC, 21'h001BD}, '{21'h001F4, 21'h001F5},
        '{21'h0023B, 21'h0023C}, '{21'h00241, 21'h00242}, '{21'h01EF2, 21'h01EF3},
        '{21'h00386, 21'h003AC}, '{21'h003F7, 21'h003F8}, '{21'h003FA, 21'h003FB}
    };

    localparam t_triple_row DIGRAPH_ROWS [N_DIGRAPH] = '{
        '{21'h001C4, 21'h001C5, 21'h001C6},
        '{21'h001C7, 21'h001C8, 21'h001C9},
        '{21'h001CA, 21'h001CB, 21'h001CC},
        '{21'h001F1, 21'h001F2, 21'h001F3}
    };

endpackage

[src/ucm_map_upper.sv]
// Uppercase mapping of one code point against the constant tables.
module ucm_map_upper (
    input  ucm_pkg::t_cp      i_code,
    input  logic              i_title,
    output ucm_pkg::t_map_res o_map
);
    import ucm_pkg::*;

    logic [N_OFFSET-1:0]  off_hit;
    logic [N_ALT-1:0]     alt_hit;
    logic [N_DIRECT-1:0]  dir_hit;
    logic [N_DIGRAPH-1:0] dg_title_hit;
    logic [N_DIGRAPH-1:0] dg_plain_hit;
    t_cp                  off_val;
    t_cp                  dir_val;
    t_cp                  dg_title_val;
    t_cp                  dg_plain_val;
    t_cp                  base_val;
    logic                 base_hit;

    // The first matching row of each table wins, so the scans that pick a value run from the last row down.
    always_comb begin
        off_val      = i_code;
        dir_val      = i_code;
        dg_title_val = i_code;
        dg_plain_val = i_code;
        for (int i = N_OFFSET - 1; i >= 0; i--) begin
            off_hit[i] = (i_code >= OFFSET_ROWS[i].lb) && (i_code <= OFFSET_ROWS[i].le);
            if (off_hit[i]) begin
                off_val = i_code - OFFSET_ROWS[i].lb + OFFSET_ROWS[i].ub;
            end
        end
        for (int i = 0; i < N_ALT; i++) begin
            alt_hit[i] = (i_code >= ALT_ROWS[i].lb) && (i_code <= ALT_ROWS[i].le)
                         && (i_code[0] == ALT_ROWS[i].lb[0]);
        end
        for (int i = N_DIRECT - 1; i >= 0; i--) begin
            dir_hit[i] = (i_code == DIRECT_ROWS[i].lo);
            if (dir_hit[i]) begin
                dir_val = DIRECT_ROWS[i].up;
            end
        end
        for (int i = N_DIGRAPH - 1; i >= 0; i--) begin
            dg_title_hit[i] = (i_code == DIGRAPH_ROWS[i].up) || (i_code == DIGRAPH_ROWS[i].lo);
            dg_plain_hit[i] = (i_code == DIGRAPH_ROWS[i].title)
                              || (i_code == DIGRAPH_ROWS[i].lo);
            if (dg_title_hit[i]) begin
                dg_title_val = DIGRAPH_ROWS[i].title;
            end
            if (dg_plain_hit[i]) begin
                dg_plain_val = DIGRAPH_ROWS[i].up;
            end
        end
    end

    always_comb begin
        base_hit = 1'b1;
        priority if (|off_hit) begin
            base_val = off_val;
        end else if (|alt_hit) begin
            base_val = i_code - t_cp'(1);
        end else if (|dir_hit) begin
            base_val = dir_val;
        end else if (i_code == FINAL_SIGMA) begin
            base_val = CAP_SIGMA;
        end else begin
            base_val = i_code;
            base_hit = 1'b0;
        end
    end

    always_comb begin
        priority if (base_hit) begin
            o_map.plain = base_val;
            o_map.moded = base_val;
        end else begin
            o_map.plain = (|dg_plain_hit) ? dg_plain_val : i_code;
            if (i_title) begin
                o_map.moded = (|dg_title_hit) ? dg_title_val : i_code;
            end else begin
                o_map.moded = (|dg_plain_hit) ? dg_plain_val : i_code;
            end
        end
    end

endmodule

[src/ucm_map_lower.sv]
// Lowercase mapping of one code point against the constant tables.
module ucm_map_lower (
    input  ucm_pkg::t_cp      i_code,
    input  logic              i_final,
    output ucm_pkg::t_map_res o_map
);
    import ucm_pkg::*;

    logic [N_OFFSET-1:0]  off_hit;
    logic [N_ALT-1:0]     alt_hit;
    logic [N_DIRECT-1:0]  dir_hit;
    logic [N_DIGRAPH-1:0] dg_hit;
    t_cp                  off_val;
    t_cp                  dir_val;
    t_cp                  dg_val;

    // The first matching row of each table wins, so the scans that pick a value run from the last row down.
    always_comb begin
        off_val = i_code;
        dir_val = i_code;
        dg_val  = i_code;
        for (int i = N_OFFSET - 1; i >= 0; i--) begin
            off_hit[i] = (i_code >= OFFSET_ROWS[i].ub) && (i_code <= OFFSET_ROWS[i].ue);
            if (off_hit[i]) begin
                off_val = i_code - OFFSET_ROWS[i].ub + OFFSET_ROWS[i].lb;
            end
        end
        for (int i = 0; i < N_ALT; i++) begin
            alt_hit[i] = (i_code >= ALT_ROWS[i].ub) && (i_code <= ALT_ROWS[i].ue)
                         && (i_code[0] == ALT_ROWS[i].ub[0]);
        end
        for (int i = N_DIRECT - 1; i >= 0; i--) begin
            dir_hit[i] = (i_code == DIRECT_ROWS[i].up);
            if (dir_hit[i]) begin
                dir_val = DIRECT_ROWS[i].lo;
            end
        end
        for (int i = N_DIGRAPH - 1; i >= 0; i--) begin
            dg_hit[i] = (i_code == DIGRAPH_ROWS[i].up) || (i_code == DIGRAPH_ROWS[i].title);
            if (dg_hit[i]) begin
                dg_val = DIGRAPH_ROWS[i].lo;
            end
        end
    end

    always_comb begin
        priority if (|off_hit) begin
            o_map.plain = off_val;
        end else if (|alt_hit) begin
            o_map.plain = i_code + t_cp'(1);
        end else if (|dir_hit) begin
            o_map.plain = dir_val;
        end else if (|dg_hit) begin
            o_map.plain = dg_val;
        end else begin
            o_map.plain = i_code;
        end
        o_map.moded = (i_final && (i_code == CAP_SIGMA)) ? FINAL_SIGMA : o_map.plain;
    end

endmodule

[src/unicode_case_mapper_core.sv]
// Top level of the Unicode case mapper: request register, mapping logic and result register.
// The block maps one code point per clock cycle and never stalls: o_busy is always low, so a
// request is taken at every edge where i_start is high. Each result appears on the o_ result
// ports for exactly one cycle, marked by o_valid; it passes through the request register and
// then the result register, with the table compare logic between them. Results come out in
// request order and cannot be held off by the receiver.
module unicode_case_mapper_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  ucm_pkg::t_cp i_code_point,
    input  logic         i_titlecase_mode,
    input  logic         i_final_sigma_mode,
    output logic         o_valid,
    output ucm_pkg::t_cp o_upper_code,
    output ucm_pkg::t_cp o_lower_code,
    output logic         o_is_upper_flag,
    output logic         o_is_lower_flag
);
    import ucm_pkg::*;

    logic     r_in_valid;
    t_cp      r_cp;
    logic     r_title;
    logic     r_final;
    logic     r_out_valid;
    t_cp      r_upper;
    t_cp      r_lower;
    logic     r_is_upper;
    logic     r_is_lower;
    logic     n_in_valid;
    t_map_res upper_map;
    t_map_res lower_map;

    assign o_busy     = 1'b0;
    assign n_in_valid = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_cp    <= i_code_point;
            r_title <= i_titlecase_mode;
            r_final <= i_final_sigma_mode;
        end
        if (r_in_valid) begin
            r_upper    <= upper_map.moded;
            r_lower    <= lower_map.moded;
            r_is_upper <= (lower_map.plain != r_cp);
            r_is_lower <= (upper_map.plain != r_cp);
        end
    end

    ucm_map_upper u_map_upper (
        .i_code  (r_cp),
        .i_title (r_title),
        .o_map   (upper_map)
    );

    ucm_map_lower u_map_lower (
        .i_code  (r_cp),
        .i_final (r_final),
        .o_map   (lower_map)
    );

    assign o_valid         = r_out_valid;
    assign o_upper_code    = r_upper;
    assign o_lower_code    = r_lower;
    assign o_is_upper_flag = r_is_upper;
    assign o_is_lower_flag = r_is_lower;

endmodule

[src/ucm_checker.sv]
// Port-level checker for the Unicode case mapper and its bind to the top level.
module ucm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_start,
    input logic         o_busy,
    input ucm_pkg::t_cp i_code_point,
    input logic         i_titlecase_mode,
    input logic         i_final_sigma_mode,
    input logic         o_valid,
    input ucm_pkg::t_cp o_upper_code,
    input ucm_pkg::t_cp o_lower_code,
    input logic         o_is_upper_flag,
    input logic         o_is_lower_flag
);
    import ucm_pkg::*;

    localparam t_cp MAX_SCALAR = 21'h10FFFF;

    // Every request produces exactly one result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> ##1 !o_valid)
        else $error("result without request");

    // The upper-case flag tracks whether the delivered lowercase form differs from the input.
    a_upper_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_upper_flag == (o_lower_code != $past(i_code_point, 2))))
        else $error("upper-case flag disagrees with lowercase result");

    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_code_point, 2) > MAX_SCALAR)) |->
        (!o_is_upper_flag && !o_is_lower_flag
         && (o_upper_code == $past(i_code_point, 2))
         && (o_lower_code == $past(i_code_point, 2))))
        else $error("code point beyond range was mapped");

endmodule

bind unicode_case_mapper_core ucm_checker u_ucm_checker (.*);
